// ----- design/vector_angle_3d_macros.svh -----
// ----------------------------------------------------------------------------
// vector_angle_3d assertion macros
// Shorthand for clocked checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ANGLE_3D_MACROS_SVH
`define VECTOR_ANGLE_3D_MACROS_SVH

// Same-cycle implication.
`define VANG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VANG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/vang_pkg.sv -----
// ----------------------------------------------------------------------------
// vang_pkg
// Shared types and constants of the 3D vector angle block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vang_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int FIFO_DEPTH    = 4;
	localparam int SQRT_STEPS    = 32;
	localparam int DIV_STEPS     = 30;
	localparam int CORDIC_STEPS  = 30;

	localparam logic [31:0] Q30_PI          = 32'd3373259426;
	localparam logic [31:0] Q30_HALF_PI     = 32'd1686629713;
	localparam logic [30:0] Q30_ONE         = 31'h4000_0000;
	localparam logic [31:0] DEG_PER_RAD_Q26 = 32'd3845054675;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
	};

	// Input beat: two vectors, signed fixed point.
	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
	} vec_t;

	// Output beat.
	typedef struct packed {
		logic [23:0] angle;
		logic        zero_error;
	} res_t;

	// Classified job handed from the front to the back.
	typedef struct packed {
		logic        zero;
		logic        neg;
		logic [63:0] dmag;
		logic [63:0] sa;
		logic [63:0] sb;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ----- design/vang_front.sv -----
// ----------------------------------------------------------------------------
// vang_front
// Accepts vector pairs, forms squared lengths and dot product, classifies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vang_front import vang_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic vec_valid,
	output logic vec_ready,
	input  vec_t vec,
	output logic job_valid,
	input  logic job_ready,
	output job_t job
);

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic [63:0] pa_s1 [3];
	logic [63:0] pb_s1 [3];
	logic signed [63:0] pd_s1 [3];
	logic [63:0] sa_s2, sb_s2;
	logic signed [65:0] dot_s2;
	job_t job_s3;
	logic signed [31:0] a [3];
	logic signed [31:0] b [3];
	logic signed [63:0] sqa [3];
	logic signed [63:0] sqb [3];

	assign a[0] = vec.ax;
	assign a[1] = vec.ay;
	assign a[2] = vec.az;
	assign b[0] = vec.bx;
	assign b[1] = vec.by;
	assign b[2] = vec.bz;

	// advance unless the last stage holds a job the queue refuses
	assign adv       = !v_s3 || job_ready;
	assign vec_ready = adv;
	assign job_valid = v_s3;
	assign job       = job_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vec_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sqa[i] = a[i] * a[i];
			sqb[i] = b[i] * b[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= sqa[i];
				pb_s1[i] <= sqb[i];
				pd_s1[i] <= a[i] * b[i];
			end
			sa_s2  <= pa_s1[0] + pa_s1[1] + pa_s1[2];
			sb_s2  <= pb_s1[0] + pb_s1[1] + pb_s1[2];
			dot_s2 <= 66'(pd_s1[0]) + 66'(pd_s1[1]) + 66'(pd_s1[2]);
			job_s3.zero <= (sa_s2 == '0) || (sb_s2 == '0);
			job_s3.neg  <= dot_s2[65];
			job_s3.dmag <= dot_s2[65] ? 64'(-dot_s2) : dot_s2[63:0];
			job_s3.sa   <= sa_s2;
			job_s3.sb   <= sb_s2;
		end
	end

endmodule

// ----- design/vang_fifo.sv -----
// ----------------------------------------------------------------------------
// vang_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vang_fifo import vang_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wvalid,
	output logic       wready,
	input  job_t       wdata,
	output logic       rvalid,
	input  logic       rready,
	output job_t       rdata,
	output fifo_stat_t stat
);

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);

	job_t mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push, pop, full, empty;

	assign full   = (count_q == CW'(FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign wready = !full;
	assign rvalid = !empty;
	assign push   = wvalid && !full;
	assign pop    = rready && !empty;
	assign rdata  = mem_q[rd_ptr_q];
	assign stat   = '{push: push, pop: pop, full: full, empty: empty};

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/vang_back.sv -----
// ----------------------------------------------------------------------------
// vang_back
// Normalize, root, divide, acos by CORDIC and scale, one stage per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vang_back import vang_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	input  logic degrees,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int NST = 2 + SQRT_STEPS + 2 + DIV_STEPS + 3 + SQRT_STEPS + CORDIC_STEPS + 3;
	localparam int RSH = 30 - FRAC_BITS;
	localparam int DSH = 56 - FRAC_BITS;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] r;
	} sq_t;

	typedef struct packed {
		sq_t         a;
		sq_t         b;
		logic [63:0] dsh;
		logic        neg;
		logic        zero;
	} rt1_t;

	typedef struct packed {
		logic [63:0]          r;
		logic [DIV_STEPS-1:0] c;
		logic [63:0]          prod;
		logic                 sat;
		logic                 neg;
		logic                 zero;
	} div_t;

	typedef struct packed {
		sq_t         q;
		logic [30:0] c;
		logic        neg;
		logic        zero;
	} rt2_t;

	typedef struct packed {
		logic signed [35:0] x;
		logic signed [35:0] y;
		logic signed [32:0] z;
		logic               neg;
		logic               zero;
	} cor_t;

	// one digit of the bitwise square root
	function automatic sq_t sqrt_step(input sq_t s, input int i);
		logic [64:0] bit_v;
		logic [64:0] trial;
		sq_t o;
		bit_v = 65'd1 << (62 - 2 * i);
		trial = {1'b0, s.r} + bit_v;
		if ({1'b0, s.v} >= trial) begin
			o.v = s.v - trial[63:0];
			o.r = (s.r >> 1) + bit_v[63:0];
		end else begin
			o.v = s.v;
			o.r = s.r >> 1;
		end
		return o;
	endfunction

	// number of bit pairs to shift left until the value reaches 2^60
	function automatic logic [4:0] norm_shift(input logic [63:0] sq);
		logic [5:0] p;
		logic [6:0] d;
		p = '0;
		for (int j = 0; j < 64; j++) begin
			if (sq[j]) begin
				p = 6'(j);
			end
		end
		d = 7'd61 - {1'b0, p};
		if (p >= 6'd60) begin
			return '0;
		end
		return d[5:1];
	endfunction

	function automatic rt1_t rt1_step(input rt1_t s, input int i);
		rt1_t o;
		o   = s;
		o.a = sqrt_step(s.a, i);
		o.b = sqrt_step(s.b, i);
		return o;
	endfunction

	function automatic rt2_t rt2_step(input rt2_t s, input int i);
		rt2_t o;
		o   = s;
		o.q = sqrt_step(s.q, i);
		return o;
	endfunction

	// one quotient bit of restoring division
	function automatic div_t div_step(input div_t s);
		logic [64:0] tw;
		div_t o;
		o  = s;
		tw = {s.r, 1'b0};
		if (tw >= {1'b0, s.prod}) begin
			o.r = 64'(tw - {1'b0, s.prod});
			o.c = {s.c[DIV_STEPS-2:0], 1'b1};
		end else begin
			o.r = tw[63:0];
			o.c = {s.c[DIV_STEPS-2:0], 1'b0};
		end
		return o;
	endfunction

	// one CORDIC vectoring rotation
	function automatic cor_t cor_step(input cor_t s, input int i);
		logic signed [35:0] xs;
		logic signed [35:0] ys;
		cor_t o;
		o  = s;
		xs = s.x >>> i;
		ys = s.y >>> i;
		if (s.y > 36'sd0) begin
			o.x = s.x + ys;
			o.y = s.y - xs;
			o.z = s.z + $signed({1'b0, ATAN_TAB[i]});
		end else begin
			o.x = s.x - ys;
			o.y = s.y + xs;
			o.z = s.z - $signed({1'b0, ATAN_TAB[i]});
		end
		return o;
	endfunction

	logic adv;
	logic [NST-1:0] vld_q;

	job_t        j_s1;
	logic [4:0]  k_s1, m_s1;
	logic [63:0] na_s2, nb_s2, dsh_s2;
	logic        neg_s2, zero_s2;
	rt1_t        rt1_in;
	rt1_t        rt1_s [SQRT_STEPS];
	logic [63:0] prod_s3, dsh_s3;
	logic        neg_s3, zero_s3;
	div_t        div_s4;
	div_t        div_s [DIV_STEPS];
	logic [30:0] c_s5, c_s6, c_s7;
	logic        neg_s5, zero_s5, neg_s6, zero_s6, neg_s7, zero_s7;
	logic [61:0] csq_s6;
	logic [63:0] t_s7;
	rt2_t        rt2_in;
	rt2_t        rt2_s [SQRT_STEPS];
	cor_t        cor_in;
	cor_t        cor_s [CORDIC_STEPS];
	logic [31:0] zc;
	logic [31:0] ang_s8, ang_s9;
	logic        zero_s8, zero_s9;
	logic [63:0] dp_s9;
	res_t        res_s10;
	logic [32:0] rsum;
	logic [64:0] dsum;
	logic [64:0] val;
	div_t        div_last;
	cor_t        cor_last;

	// the whole back pipeline moves as one; stall only on a held result
	assign res_valid = vld_q[NST-1];
	assign adv       = !res_valid || res_ready;
	assign job_ready = adv;
	assign res       = res_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], job_valid};
		end
	end

	// normalize both squared lengths
	always_ff @(posedge clk) begin
		if (adv) begin
			j_s1    <= job;
			k_s1    <= norm_shift(job.sa);
			m_s1    <= norm_shift(job.sb);
			na_s2   <= j_s1.sa << {k_s1, 1'b0};
			nb_s2   <= j_s1.sb << {m_s1, 1'b0};
			dsh_s2  <= j_s1.dmag << (6'(k_s1) + 6'(m_s1));
			neg_s2  <= j_s1.neg;
			zero_s2 <= j_s1.zero;
		end
	end

	always_comb begin
		rt1_in.a.v  = na_s2;
		rt1_in.a.r  = '0;
		rt1_in.b.v  = nb_s2;
		rt1_in.b.r  = '0;
		rt1_in.dsh  = dsh_s2;
		rt1_in.neg  = neg_s2;
		rt1_in.zero = zero_s2;
	end

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_rt1
		rt1_t cur;
		if (g == 0) begin : g_head
			assign cur = rt1_in;
		end else begin : g_tail
			assign cur = rt1_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rt1_s[g] <= rt1_step(cur, g);
			end
		end
	end

	// product of the lengths, then clamp test
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= rt1_s[SQRT_STEPS-1].a.r[31:0] * rt1_s[SQRT_STEPS-1].b.r[31:0];
			dsh_s3  <= rt1_s[SQRT_STEPS-1].dsh;
			neg_s3  <= rt1_s[SQRT_STEPS-1].neg;
			zero_s3 <= rt1_s[SQRT_STEPS-1].zero;
			div_s4.r    <= dsh_s3;
			div_s4.c    <= '0;
			div_s4.prod <= prod_s3;
			div_s4.sat  <= dsh_s3 >= prod_s3;
			div_s4.neg  <= neg_s3;
			div_s4.zero <= zero_s3;
		end
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		div_t cur;
		if (g == 0) begin : g_head
			assign cur = div_s4;
		end else begin : g_tail
			assign cur = div_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[g] <= div_step(cur);
			end
		end
	end

	assign div_last = div_s[DIV_STEPS-1];

	// cosine, its square, and 1 - cos^2
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s5    <= div_last.sat ? Q30_ONE : {1'b0, div_last.c};
			neg_s5  <= div_last.neg;
			zero_s5 <= div_last.zero;
			csq_s6  <= c_s5 * c_s5;
			c_s6    <= c_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
			t_s7    <= (64'd1 << 60) - 64'(csq_s6);
			c_s7    <= c_s6;
			neg_s7  <= neg_s6;
			zero_s7 <= zero_s6;
		end
	end

	always_comb begin
		rt2_in.q.v  = t_s7;
		rt2_in.q.r  = '0;
		rt2_in.c    = c_s7;
		rt2_in.neg  = neg_s7;
		rt2_in.zero = zero_s7;
	end

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_rt2
		rt2_t cur;
		if (g == 0) begin : g_head
			assign cur = rt2_in;
		end else begin : g_tail
			assign cur = rt2_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rt2_s[g] <= rt2_step(cur, g);
			end
		end
	end

	always_comb begin
		cor_in.x    = $signed({5'd0, rt2_s[SQRT_STEPS-1].c});
		cor_in.y    = $signed({4'd0, rt2_s[SQRT_STEPS-1].q.r[31:0]});
		cor_in.z    = '0;
		cor_in.neg  = rt2_s[SQRT_STEPS-1].neg;
		cor_in.zero = rt2_s[SQRT_STEPS-1].zero;
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cor
		cor_t cur;
		if (g == 0) begin : g_head
			assign cur = cor_in;
		end else begin : g_tail
			assign cur = cor_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				cor_s[g] <= cor_step(cur, g);
			end
		end
	end

	assign cor_last = cor_s[CORDIC_STEPS-1];

	// clamp to [0, pi/2]
	always_comb begin
		priority if (cor_last.z < 33'sd0) begin
			zc = '0;
		end else if (cor_last.z > $signed({1'b0, Q30_HALF_PI})) begin
			zc = Q30_HALF_PI;
		end else begin
			zc = cor_last.z[31:0];
		end
	end

	always_comb begin
		rsum = {1'b0, ang_s9} + (33'd1 << (RSH - 1));
		dsum = {1'b0, dp_s9} + (65'd1 << (DSH - 1));
		val  = degrees ? (dsum >> DSH) : 65'(rsum >> RSH);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s8  <= cor_last.neg ? Q30_PI - zc : zc;
			zero_s8 <= cor_last.zero;
			dp_s9   <= ang_s8 * DEG_PER_RAD_Q26;
			ang_s9  <= ang_s8;
			zero_s9 <= zero_s8;
			if (zero_s9) begin
				res_s10.angle      <= '0;
				res_s10.zero_error <= 1'b1;
			end else begin
				res_s10.angle      <= (|val[64:24]) ? '1 : val[23:0];
				res_s10.zero_error <= 1'b0;
			end
		end
	end

endmodule

// ----- design/vector_angle_3d.sv -----
// ----------------------------------------------------------------------------
// vector_angle_3d
// Angle between two 3D fixed-point vectors, in radians or degrees.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  vec       in         vec_valid/vec_ready   vec_t  (ax..bz, signed Q16.16)
//  res       out        res_valid/res_ready   res_t  (angle Q.16, zero_error)
//  cfg       in         cfg_we                cfg_wdata (degrees_mode)
//
//  One beat is accepted per cycle while vec_ready is high; it passes the
//  front, the queue and the back, whose depth is set by the two 32-step
//  square roots, the 30-step divider and the 30-step CORDIC, one per stage.
//  Reset clears the pipeline valids, the queue pointers and degrees_mode.
//  A stalled result holds the back pipeline; the queue absorbs the front
//  until it fills, then vec_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vector_angle_3d_macros.svh"

module vector_angle_3d import vang_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vec_valid,
	output logic vec_ready,
	input  vec_t vec,
	output logic res_valid,
	input  logic res_ready,
	output res_t res,
	input  logic cfg_we,
	input  logic cfg_wdata
);

	logic       degrees_q;
	logic       f_valid, f_ready;
	job_t       f_job;
	logic       b_valid, b_ready;
	job_t       b_job;
	fifo_stat_t fs;

	// mode register; the user must write it only while the block is idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degrees_q <= 1'b0;
		end else if (cfg_we) begin
			degrees_q <= cfg_wdata;
		end
	end

	// front: multiply, sum, classify
	vang_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_valid (vec_valid),
		.vec_ready (vec_ready),
		.vec       (vec),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	// queue: decouple the front stalls from the back stalls
	vang_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wvalid (f_valid),
		.wready (f_ready),
		.wdata  (f_job),
		.rvalid (b_valid),
		.rready (b_ready),
		.rdata  (b_job),
		.stat   (fs)
	);

	// back: lengths, cosine, acos, scaling
	vang_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.degrees   (degrees_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	`VANG_ASSERT_NOW(a_zero_angle, res_valid && res.zero_error, res.angle == '0, "zero vector with nonzero angle")
	`VANG_ASSERT_NEXT(a_push_fills, fs.push && !fs.pop, !fs.empty, "queue empty after a lone push")
	`VANG_ASSERT_NEXT(a_pop_frees, fs.pop && !fs.push, !fs.full, "queue full after a lone pop")

endmodule

// ----- dv/vector_angle_3d_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_3d_tb
// Self-checking bench for the 3D vector angle block. A queue-fed driver
// offers vector pairs and a clocked monitor checks each result beat against
// a bit-exact integer model of the dot/length/divide/CORDIC path, in both
// radians and degrees mode, with random idling and a long output stall.
// ----------------------------------------------------------------------------
module vector_angle_3d_tb;
	import vang_pkg::*;

	localparam int FRAC     = FRAC_BITS_DEF;
	localparam int LIMIT    = 1000000;
	localparam int SETTLE   = 200;      // beyond the pipeline latency
	localparam int HOLD_LEN = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vec_valid;
	logic vec_ready;
	vec_t vec;
	logic res_valid;
	logic res_ready;
	res_t res;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	vector_angle_3d DUT (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_ready(vec_ready), .vec(vec),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	vec_t pairs_to_send[$];
	res_t angles_due[$];
	logic deg_mode = 1'b0;
	int cycle = 0;
	int mismatches = 0;
	int beats_in = 0, beats_out = 0, zero_hits = 0;
	logic hold_go = 1'b0, hold_done = 1'b0;
	int hold_cnt = 0;

	// Free-running clock.
	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Bit-exact angle model
	// ------------------------------------------------------------------
	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] r, bt;
		r = 0;
		bt = 64'h4000_0000_0000_0000;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v = v - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// Normalize a nonzero squared length to >= 2^60 by even shifts; return its root.
	function automatic logic [63:0] unit_length(logic [63:0] sq, output int sh);
		sh = 0;
		while (sh < 30 && sq < 64'h1000_0000_0000_0000) begin
			sq = sq << 2;
			sh++;
		end
		return root_floor(sq);
	endfunction

	function automatic res_t angle_of(vec_t v, logic degs);
		longint av[3], bv[3];
		longint p, x, y, xs, ys, z, ang;
		logic [63:0] sa, sb, pos, neg, dmag, la, lb, prod, c, r, full;
		int k, m;
		logic negf;
		res_t o;
		av[0] = v.ax; av[1] = v.ay; av[2] = v.az;
		bv[0] = v.bx; bv[1] = v.by; bv[2] = v.bz;
		sa = 0; sb = 0; pos = 0; neg = 0;
		for (int i = 0; i < 3; i++) begin
			sa += 64'(av[i] * av[i]);
			sb += 64'(bv[i] * bv[i]);
			p = av[i] * bv[i];
			if (p >= 0) pos += 64'(p);
			else neg += 64'(-p);
		end
		o = '0;
		if (sa == 0 || sb == 0) begin
			o.zero_error = 1'b1;
			return o;
		end
		negf = neg > pos;
		dmag = negf ? neg - pos : pos - neg;
		la = unit_length(sa, k);
		lb = unit_length(sb, m);
		dmag = dmag << (k + m);
		prod = la * lb;
		// Clamp cos to 1 when |dot| reaches the length product.
		if (dmag >= prod) begin
			c = 64'd1 << 30;
		end else begin
			c = 0;
			r = dmag;
			for (int i = 0; i < 30; i++) begin
				c = c << 1;
				if (r >= prod - r) begin
					r = r - (prod - r);
					c = c | 1;
				end else begin
					r = r << 1;
				end
			end
		end
		x = longint'(c);
		y = longint'(root_floor((64'd1 << 60) - c * c));
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
			end else begin
				x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(Q30_HALF_PI)) z = longint'(Q30_HALF_PI);
		ang = negf ? longint'(Q30_PI) - z : z;
		if (degs) full = (64'(ang) * 64'(DEG_PER_RAD_Q26) + (64'd1 << (55 - FRAC))) >> (56 - FRAC);
		else full = (64'(ang) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
		o.angle = (full > 64'hFF_FFFF) ? 24'hFF_FFFF : full[23:0];
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Idling: random gaps, except in a long quiet stretch that opens each period of counted cycles
	// ------------------------------------------------------------------
	function automatic logic gap_now();
		return (cycle % 2000) >= 700 && $urandom_range(0, 99) < 15;
	endfunction

	// Driver: record the accepted beat, then offer the next pair or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_valid <= 1'b0;
			vec <= '0;
		end else begin
			if (vec_valid && vec_ready) begin
				angles_due.push_back(angle_of(vec, deg_mode));
				beats_in++;
			end
			// Hold the beat until it is taken.
			if (!vec_valid || vec_ready) begin
				if (pairs_to_send.size() > 0 && !gap_now()) begin
					vec_valid <= 1'b1;
					vec <= pairs_to_send.pop_front();
				end else begin
					vec_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, requested once by the stimulus.
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt >= HOLD_LEN) hold_done <= 1'b1;
		end
	end

	// Monitor: check each result beat against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				beats_out++;
				if (angles_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0d] unexpected result beat angle=%0d zero_error=%0b",
							cycle, res.angle, res.zero_error);
				end else begin
					res_t want;
					want = angles_due.pop_front();
					if (want.zero_error) zero_hits++;
					if (want.angle !== res.angle || want.zero_error !== res.zero_error) begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0d] mismatch: angle exp %0d got %0d, zero_error exp %0b got %0b",
								cycle, want.angle, res.angle, want.zero_error, res.zero_error);
					end
				end
			end
			res_ready <= (hold_go && !hold_done) ? 1'b0 : !gap_now();
		end
	end

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("timeout with %0d results outstanding", angles_due.size());
			$display("** vector_angle_3d: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic vec_t make_pair(int a0, int a1, int a2, int b0, int b1, int b2);
		vec_t v;
		v.ax = a0; v.ay = a1; v.az = a2;
		v.bx = b0; v.by = b1; v.bz = b2;
		return v;
	endfunction

	function automatic int rnd_comp(int style);
		case (style)
			0: return int'($urandom());
			1: return $urandom_range(0, 2000) - 1000;
			2: return int'($urandom()) >>> $urandom_range(0, 30);
			default: return 0;
		endcase
	endfunction

	// Random pair: mostly generic, some parallel, antiparallel, orthogonal or zero.
	function automatic vec_t rnd_pair();
		vec_t v;
		int st, kind;
		st = $urandom_range(0, 2);
		kind = $urandom_range(0, 99);
		v = make_pair(rnd_comp(st), rnd_comp(st), rnd_comp(st),
			rnd_comp(st), rnd_comp(st), rnd_comp(st));
		if (kind < 10) begin
			v.bx = v.ax; v.by = v.ay; v.bz = v.az;
		end else if (kind < 20) begin
			v.bx = -(v.ax >>> 1); v.by = -(v.ay >>> 1); v.bz = -(v.az >>> 1);
		end else if (kind < 28) begin
			v.bx = -v.ay; v.by = v.ax; v.bz = 0; v.az = $urandom_range(0, 1) ? v.az : 0;
			if (v.az != 0) v.bz = 0;
		end else if (kind < 33) begin
			v.ax = 0; v.ay = 0; v.az = 0;
		end else if (kind < 38) begin
			v.bx = 0; v.by = 0; v.bz = 0;
		end
		return v;
	endfunction

	task automatic queue_directed();
		int mx, mn;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		pairs_to_send.push_back(make_pair(0, 0, 0, 0, 0, 0));
		pairs_to_send.push_back(make_pair(0, 0, 0, 1, 2, 3));
		pairs_to_send.push_back(make_pair(5, 0, 0, 0, 0, 0));
		pairs_to_send.push_back(make_pair(65536, 0, 0, 65536, 0, 0));
		pairs_to_send.push_back(make_pair(65536, 0, 0, -65536, 0, 0));
		pairs_to_send.push_back(make_pair(65536, 0, 0, 0, 65536, 0));
		pairs_to_send.push_back(make_pair(1, 0, 0, 0, 0, 1));
		pairs_to_send.push_back(make_pair(1, 1, 1, 1, 1, 1));
		pairs_to_send.push_back(make_pair(1, 0, 0, -1, 0, 0));
		pairs_to_send.push_back(make_pair(mx, mx, mx, mx, mx, mx));
		pairs_to_send.push_back(make_pair(mn, mn, mn, mn, mn, mn));
		pairs_to_send.push_back(make_pair(mn, mn, mn, mx, mx, mx));
		pairs_to_send.push_back(make_pair(mx, mn, mx, mn, mx, mn));
		pairs_to_send.push_back(make_pair(mn, 0, 0, mn, 0, 0));
		pairs_to_send.push_back(make_pair(mn, 0, 0, 0, mx, 0));
		pairs_to_send.push_back(make_pair(-1, -1, -1, mx, mx, mx));
		pairs_to_send.push_back(make_pair(1, 0, 0, 1, 1, 0));
		pairs_to_send.push_back(make_pair(1, 0, 0, -1, 1, 0));
		pairs_to_send.push_back(make_pair(mx, 1, 0, mx, 0, 1));
		pairs_to_send.push_back(make_pair(1, 0, 0, 1, mx, 0));
		pairs_to_send.push_back(make_pair(-1, 0, 0, 1, mx, 0));
	endtask

	// Wait for an empty pipeline, then a margin before any register write.
	task automatic drain();
		while (pairs_to_send.size() > 0 || vec_valid || angles_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(logic val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		deg_mode = val;
	endtask

	task automatic run_phase(logic val, int n_rand, logic stall);
		drain();
		write_mode(val);
		queue_directed();
		for (int i = 0; i < n_rand; i++) pairs_to_send.push_back(rnd_pair());
		if (stall) hold_go = 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_phase(1'b0, 280, 1'b0);
		run_phase(1'b1, 280, 1'b1);   // output stall backs up the queue here
		run_phase(1'b0, 150, 1'b0);
		run_phase(1'b1, 150, 1'b0);
		drain();
		$display("covered %0d pairs in radians and degrees mode, %0d zero-vector cases,",
			beats_in, zero_hits);
		$display("random gaps on both sides and a %0d-cycle output stall", HOLD_LEN);
		if (mismatches == 0) begin
			$display("** vector_angle_3d: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** vector_angle_3d: FAILED **");
		end
		$finish;
	end

endmodule
